// ===== hdl/slkv_pkg.sv =====
// Shared types and constants of the skip-list key-value store.
// No dependencies; imported by every module of the block.
package slkv_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 11;
  localparam int LIMIT_W     = 4;
  localparam int THRESH_W    = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 40;
  localparam int RES_W       = 36;
  localparam int LIMIT_DEFAULT = 5;

  // operation codes; the unused code acts as a search
  localparam logic [1:0] FUNC_SEARCH = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_ERASE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  typedef enum logic [2:0] {
    OUT_FOUND     = 3'd0,
    OUT_NOT_FOUND = 3'd1,
    OUT_INSERTED  = 3'd2,
    OUT_UPDATED   = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_ERASED    = 3'd5
  } outcome_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LVL,
    ST_LINK,
    ST_KEY,
    ST_CMP,
    ST_HIT,
    ST_FOUND,
    ST_COIN,
    ST_RAISE,
    ST_POP,
    ST_ILINK,
    ST_IW1,
    ST_IW2,
    ST_ELINK,
    ST_ECHK,
    ST_EW,
    ST_EFIN,
    ST_LOWER,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic pop;
    logic push;
  } free_ctl_t;

endpackage

// ===== hdl/slkv_coin.sv =====
// Galois LFSR coin for level draws of new nodes.
// Depends on slkv_pkg.
module slkv_coin import slkv_pkg::*; #(
  parameter int COIN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [THRESH_W-1:0] threshold,
  output logic                coin_ok
);

  localparam logic [COIN_BITS-1:0] TAPS = COIN_BITS'(32'h0000B400);
  localparam logic [COIN_BITS-1:0] SEED = COIN_BITS'(32'h0000ACE1);

  logic [COIN_BITS-1:0] lfsr_r;
  logic [COIN_BITS-1:0] lfsr_nxt;
  logic [THRESH_W-1:0]  draw;

  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ TAPS) : (lfsr_r >> 1);

  // take the top sixteen bits, or widen a short register to sixteen
  generate
    if (COIN_BITS >= THRESH_W) begin : g_wide
      assign draw = lfsr_nxt[COIN_BITS-1 -: THRESH_W];
    end else begin : g_narrow
      assign draw = {lfsr_nxt, {(THRESH_W-COIN_BITS){1'b0}}};
    end
  endgenerate

  assign coin_ok = draw < threshold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED;
    end else if (step) begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

// ===== hdl/slkv_free_list.sv =====
// Free slot stack with a low-water mark standing in for its initial fill.
// Depends on slkv_pkg.
module slkv_free_list import slkv_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  free_ctl_t                    ctl,
  input  logic [$clog2(NODES)-1:0]     push_slot,
  output logic [$clog2(NODES)-1:0]     pop_slot,
  output logic [$clog2(NODES+1)-1:0]   free_count
);

  localparam int SLOT_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES+1);

  logic [SLOT_W-1:0] mem [NODES];
  logic [CNT_W-1:0]  fc_r;
  logic [CNT_W-1:0]  lw_r;
  logic [CNT_W-1:0]  top_idx;
  logic [SLOT_W-1:0] rd_r;
  logic [SLOT_W-1:0] orig_r;
  logic              use_orig_r;

  assign top_idx    = fc_r - 1'b1;
  assign free_count = fc_r;
  // entries below the low-water mark were never written and still hold their index
  assign pop_slot   = use_orig_r ? orig_r : rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= CNT_W'(NODES);
      lw_r <= CNT_W'(NODES);
    end else if (ctl.pop) begin
      fc_r <= top_idx;
      if (top_idx < lw_r) begin
        lw_r <= top_idx;
      end
    end else if (ctl.push && (fc_r < CNT_W'(NODES))) begin
      fc_r <= fc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      rd_r       <= mem[top_idx[SLOT_W-1:0]];
      orig_r     <= top_idx[SLOT_W-1:0];
      use_orig_r <= top_idx < lw_r;
    end
    if (ctl.push && !ctl.pop && (fc_r < CNT_W'(NODES))) begin
      mem[fc_r[SLOT_W-1:0]] <= push_slot;
    end
  end

endmodule

// ===== hdl/slkv_node_mem.sv =====
// Node keys, values and per-level links, one write and one registered read each.
// Depends on slkv_pkg.
module slkv_node_mem import slkv_pkg::*; #(
  parameter int NODES  = 1024,
  parameter int LVL_W  = 3,
  parameter int LINK_W = 11
) (
  input  logic                           clk,
  input  logic [$clog2(NODES)-1:0]       kv_raddr,
  input  logic                           key_we,
  input  logic                           val_we,
  input  logic [$clog2(NODES)-1:0]       kv_waddr,
  input  logic [KEY_W-1:0]               key_wdata,
  input  logic [VAL_W-1:0]               val_wdata,
  input  logic [$clog2(NODES)+LVL_W-1:0] lk_raddr,
  input  logic                           lk_we,
  input  logic [$clog2(NODES)+LVL_W-1:0] lk_waddr,
  input  logic [LINK_W-1:0]              lk_wdata,
  output logic [KEY_W-1:0]               key_rd,
  output logic [VAL_W-1:0]               val_rd,
  output logic [LINK_W-1:0]              lk_rd
);

  localparam int LK_DEPTH = NODES << LVL_W;

  logic [KEY_W-1:0]  key_mem [NODES];
  logic [VAL_W-1:0]  val_mem [NODES];
  logic [LINK_W-1:0] lk_mem  [LK_DEPTH];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[kv_waddr] <= key_wdata;
    end
    if (val_we) begin
      val_mem[kv_waddr] <= val_wdata;
    end
    if (lk_we) begin
      lk_mem[lk_waddr] <= lk_wdata;
    end
    key_rd <= key_mem[kv_raddr];
    val_rd <= val_mem[kv_raddr];
    lk_rd  <= lk_mem[lk_raddr];
  end

endmodule

// ===== hdl/skip_list_key_value_store.sv =====
// Skip-list key-value store: a sorted map of signed 32-bit keys to 32-bit values
// kept as a skip list over a pool of NODES slots. Each input word is one operation
// (search, insert or erase) and gives exactly one result word. A small sequencer
// walks the list through node memories with one read and one write port and
// registered reads, one comparator judging every key, so the length of an
// operation depends on the walk: it is accepted, steps node by node along a level
// and descends a level on each probe that stops the walk, then a search finishes
// with its result word. An insert also draws coins, takes a free slot and links
// each of its levels; an erase unlinks its levels, with an early stop where the
// node is absent from a higher level, then frees the slot, finishes and lowers
// each empty top level. in_tready is high only between operations; a finished
// result waits in the output register. The memories need no clearing pass after
// reset: the free stack tracks a low-water mark and the head links live in
// flip-flops. Configuration writes belong to idle periods only. Depends on
// slkv_pkg, slkv_coin, slkv_free_list and slkv_node_mem.
module skip_list_key_value_store import slkv_pkg::*; #(
  parameter int NODES      = 1024,
  parameter int MAX_LEVELS = 8,
  parameter int COIN_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // func[1:0], key[33:2], value[65:34], zero fill
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // success[0], value_out[32:1], outcome[35:33], zero
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SLOT_W = $clog2(NODES);
  localparam int LINK_W = $clog2(NODES+2);
  localparam int CNT_W  = $clog2(NODES+1);
  localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LVLC_W = $clog2(MAX_LEVELS+1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(NODES);
  localparam logic [LINK_W-1:0] HEAD_MARK = LINK_W'(NODES+1);

  // configuration registers
  logic [CAP_W-1:0]    capacity_r;
  logic [LIMIT_W-1:0]  level_limit_r;
  logic [THRESH_W-1:0] threshold_r;

  // sequencer state
  state_t              state_r, state_nxt;
  logic [1:0]          func_r, func_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [LINK_W-1:0]   at_r, at_nxt;
  logic [LINK_W-1:0]   nx_r, nx_nxt;
  logic [LINK_W-1:0]   hit_r, hit_nxt;
  logic [LVLC_W-1:0]   lvl_r, lvl_nxt;
  logic [LVLC_W-1:0]   new_lvl_r, new_lvl_nxt;
  logic [LVLC_W-1:0]   top_r, top_nxt;
  logic [CNT_W-1:0]    guard_r, guard_nxt;
  logic [CNT_W-1:0]    stored_r, stored_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [LINK_W-1:0]   pred_r [MAX_LEVELS];
  logic [LINK_W-1:0]   pred_nxt [MAX_LEVELS];
  logic [LINK_W-1:0]   head_r [MAX_LEVELS];
  logic [LINK_W-1:0]   head_nxt [MAX_LEVELS];
  logic                res_success_r, res_success_nxt;
  logic [VAL_W-1:0]    res_value_r, res_value_nxt;
  outcome_t            res_outcome_r, res_outcome_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  // memory and unit controls
  logic [SLOT_W-1:0]       kv_raddr;
  logic                    key_we, val_we;
  logic [SLOT_W-1:0]       kv_waddr;
  logic [KEY_W-1:0]        key_wdata;
  logic [VAL_W-1:0]        val_wdata;
  logic [SLOT_W+LVL_W-1:0] lk_raddr, lk_waddr;
  logic                    lk_we;
  logic [LINK_W-1:0]       lk_wdata;
  logic signed [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0]        val_rd;
  logic [LINK_W-1:0]       lk_rd;
  free_ctl_t               free_ctl;
  logic [SLOT_W-1:0]       pop_slot;
  logic [CNT_W-1:0]        free_count;
  logic                    coin_step;
  logic                    coin_ok;

  // derived values
  logic [LVL_W-1:0]    li;
  logic [LVL_W-1:0]    top_m1;
  logic [LINK_W-1:0]   lk_clamped;
  logic [LINK_W-1:0]   at_link;
  logic [LINK_W-1:0]   pr_link;
  logic                key_lt, key_eq, found;
  logic                store_full;
  logic [4:0]          lim_raw, lim_sat;
  logic [LVLC_W-1:0]   lim;
  logic                in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign li         = lvl_r[LVL_W-1:0];
  assign top_m1     = LVL_W'(top_r - 1'b1);
  // stored links outside the pool read as the end marker
  assign lk_clamped = (lk_rd < END_MARK) ? lk_rd : END_MARK;
  assign at_link    = (at_r == HEAD_MARK) ? head_r[li] : lk_clamped;
  assign pr_link    = (pred_r[li] == HEAD_MARK) ? head_r[li] : lk_clamped;

  // the one shared comparator: memory key against the operation key
  assign key_lt = key_rd < key_r;
  assign key_eq = key_rd == key_r;
  assign found  = (hit_r != END_MARK) && key_eq;

  assign store_full = (CMP_W'(stored_r) >= CMP_W'(capacity_r)) || (free_count == '0);

  // level limit: zero means the default, saturate at the level count
  assign lim_raw = (level_limit_r == '0) ? 5'(LIMIT_DEFAULT) : 5'(level_limit_r);
  assign lim_sat = (lim_raw > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : lim_raw;
  assign lim     = LVLC_W'(lim_sat);

  slkv_coin #(.COIN_BITS(COIN_BITS)) u_coin (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (coin_step),
    .threshold (threshold_r),
    .coin_ok   (coin_ok)
  );

  slkv_free_list #(.NODES(NODES)) u_free (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (free_ctl),
    .push_slot  (hit_r[SLOT_W-1:0]),
    .pop_slot   (pop_slot),
    .free_count (free_count)
  );

  slkv_node_mem #(.NODES(NODES), .LVL_W(LVL_W), .LINK_W(LINK_W)) u_mem (
    .clk       (clk),
    .kv_raddr  (kv_raddr),
    .key_we    (key_we),
    .val_we    (val_we),
    .kv_waddr  (kv_waddr),
    .key_wdata (key_wdata),
    .val_wdata (val_wdata),
    .lk_raddr  (lk_raddr),
    .lk_we     (lk_we),
    .lk_waddr  (lk_waddr),
    .lk_wdata  (lk_wdata),
    .key_rd    (key_rd),
    .val_rd    (val_rd),
    .lk_rd     (lk_rd)
  );

  // configuration: write only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= CAP_W'(1024);
      level_limit_r <= LIMIT_W'(5);
      threshold_r   <= THRESH_W'(32768);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY:  capacity_r    <= cfg_data[CAP_W-1:0];
        CFG_LEVEL_LIM: level_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_THRESHOLD: threshold_r   <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= LVLC_W'(1);
      stored_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= END_MARK;
      end
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r          <= func_nxt;
    key_r           <= key_nxt;
    val_r           <= val_nxt;
    at_r            <= at_nxt;
    nx_r            <= nx_nxt;
    hit_r           <= hit_nxt;
    lvl_r           <= lvl_nxt;
    new_lvl_r       <= new_lvl_nxt;
    guard_r         <= guard_nxt;
    slot_r          <= slot_nxt;
    pred_r          <= pred_nxt;
    res_success_r   <= res_success_nxt;
    res_value_r     <= res_value_nxt;
    res_outcome_r   <= res_outcome_nxt;
    out_data_r      <= out_data_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    key_nxt         = key_r;
    val_nxt         = val_r;
    at_nxt          = at_r;
    nx_nxt          = nx_r;
    hit_nxt         = hit_r;
    lvl_nxt         = lvl_r;
    new_lvl_nxt     = new_lvl_r;
    top_nxt         = top_r;
    guard_nxt       = guard_r;
    stored_nxt      = stored_r;
    slot_nxt        = slot_r;
    pred_nxt        = pred_r;
    head_nxt        = head_r;
    res_success_nxt = res_success_r;
    res_value_nxt   = res_value_r;
    res_outcome_nxt = res_outcome_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;

    kv_raddr  = at_r[SLOT_W-1:0];
    key_we    = 1'b0;
    val_we    = 1'b0;
    kv_waddr  = slot_r;
    key_wdata = key_r;
    val_wdata = val_r;
    lk_raddr  = {at_r[SLOT_W-1:0], li};
    lk_we     = 1'b0;
    lk_waddr  = {slot_r, li};
    lk_wdata  = at_link;
    free_ctl  = '0;
    coin_step = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt = in_tdata[1:0];
          key_nxt  = in_tdata[33:2];
          val_nxt  = in_tdata[65:34];
          at_nxt   = HEAD_MARK;
          lvl_nxt  = top_r;
          if ((in_tdata[1:0] == FUNC_INSERT) && store_full) begin
            // refuse at once, no change to the store
            res_success_nxt = 1'b0;
            res_value_nxt   = '0;
            res_outcome_nxt = OUT_FULL;
            state_nxt       = ST_OUT;
          end else begin
            state_nxt = ST_LVL;
          end
        end
      end
      ST_LVL: begin
        if (lvl_r == '0) begin
          // descent done: fetch level-0 successor of the last predecessor
          lk_raddr  = {at_r[SLOT_W-1:0], {LVL_W{1'b0}}};
          state_nxt = ST_HIT;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          guard_nxt = '0;
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        state_nxt = ST_KEY;
      end
      ST_KEY: begin
        if (at_link == END_MARK) begin
          pred_nxt[li] = at_r;
          state_nxt    = ST_LVL;
        end else begin
          kv_raddr  = at_link[SLOT_W-1:0];
          nx_nxt    = at_link;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!key_lt || (guard_r >= CNT_W'(NODES))) begin
          pred_nxt[li] = at_r;
          state_nxt    = ST_LVL;
        end else begin
          at_nxt    = nx_r;
          guard_nxt = guard_r + 1'b1;
          state_nxt = ST_LINK;
        end
      end
      ST_HIT: begin
        hit_nxt   = at_link;
        kv_raddr  = at_link[SLOT_W-1:0];
        state_nxt = ST_FOUND;
      end
      ST_FOUND: begin
        res_success_nxt = 1'b0;
        res_value_nxt   = '0;
        res_outcome_nxt = OUT_NOT_FOUND;
        state_nxt       = ST_OUT;
        priority case (func_r)
          FUNC_INSERT: begin
            if (found) begin
              val_we          = 1'b1;
              kv_waddr        = hit_r[SLOT_W-1:0];
              res_outcome_nxt = OUT_UPDATED;
            end else begin
              new_lvl_nxt = LVLC_W'(1);
              state_nxt   = ST_COIN;
            end
          end
          FUNC_ERASE: begin
            if (found) begin
              lvl_nxt   = '0;
              state_nxt = ST_ELINK;
            end
          end
          default: begin
            if (found) begin
              res_success_nxt = 1'b1;
              res_value_nxt   = val_rd;
              res_outcome_nxt = OUT_FOUND;
            end
          end
        endcase
      end
      ST_COIN: begin
        // one coin a cycle; a success at the limit still uses its coin
        coin_step = 1'b1;
        if (coin_ok && (new_lvl_r < lim)) begin
          new_lvl_nxt = new_lvl_r + 1'b1;
        end else begin
          state_nxt = ST_RAISE;
        end
      end
      ST_RAISE: begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          if ((LVLC_W'(i) >= top_r) && (LVLC_W'(i) < new_lvl_r)) begin
            pred_nxt[i] = HEAD_MARK;
          end
        end
        if (new_lvl_r > top_r) begin
          top_nxt = new_lvl_r;
        end
        free_ctl.pop = 1'b1;
        state_nxt    = ST_POP;
      end
      ST_POP: begin
        slot_nxt  = pop_slot;
        key_we    = 1'b1;
        val_we    = 1'b1;
        kv_waddr  = pop_slot;
        lvl_nxt   = '0;
        state_nxt = ST_ILINK;
      end
      ST_ILINK: begin
        lk_raddr  = {pred_r[li][SLOT_W-1:0], li};
        state_nxt = ST_IW1;
      end
      ST_IW1: begin
        // new node takes over its predecessor's successor
        lk_we     = 1'b1;
        lk_waddr  = {slot_r, li};
        lk_wdata  = pr_link;
        state_nxt = ST_IW2;
      end
      ST_IW2: begin
        if (pred_r[li] == HEAD_MARK) begin
          head_nxt[li] = LINK_W'(slot_r);
        end else begin
          lk_we    = 1'b1;
          lk_waddr = {pred_r[li][SLOT_W-1:0], li};
          lk_wdata = LINK_W'(slot_r);
        end
        lvl_nxt = lvl_r + 1'b1;
        if ((lvl_r + 1'b1) == new_lvl_r) begin
          stored_nxt      = stored_r + 1'b1;
          res_success_nxt = 1'b1;
          res_value_nxt   = '0;
          res_outcome_nxt = OUT_INSERTED;
          state_nxt       = ST_OUT;
        end else begin
          state_nxt = ST_ILINK;
        end
      end
      ST_ELINK: begin
        lk_raddr  = {pred_r[li][SLOT_W-1:0], li};
        state_nxt = ST_ECHK;
      end
      ST_ECHK: begin
        if (pr_link != hit_r) begin
          state_nxt = ST_EFIN;
        end else begin
          lk_raddr  = {hit_r[SLOT_W-1:0], li};
          state_nxt = ST_EW;
        end
      end
      ST_EW: begin
        // bypass the erased node at this level
        if (pred_r[li] == HEAD_MARK) begin
          head_nxt[li] = lk_clamped;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = {pred_r[li][SLOT_W-1:0], li};
          lk_wdata = lk_clamped;
        end
        lvl_nxt = lvl_r + 1'b1;
        if ((lvl_r + 1'b1) == top_r) begin
          state_nxt = ST_EFIN;
        end else begin
          state_nxt = ST_ELINK;
        end
      end
      ST_EFIN: begin
        free_ctl.push = 1'b1;
        if (stored_r != '0) begin
          stored_nxt = stored_r - 1'b1;
        end
        state_nxt = ST_LOWER;
      end
      ST_LOWER: begin
        // drop empty top levels one a cycle
        if ((top_r > LVLC_W'(1)) && (head_r[top_m1] == END_MARK)) begin
          top_nxt = top_r - 1'b1;
        end else begin
          res_success_nxt = 1'b1;
          res_value_nxt   = '0;
          res_outcome_nxt = OUT_ERASED;
          state_nxt       = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_W-RES_W){1'b0}}, res_outcome_r, res_value_r, res_success_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // every slot is either free or holds a key between operations
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      ((CNT_W+1)'(free_count) + (CNT_W+1)'(stored_r) == (CNT_W+1)'(NODES)))
    else $error("free and stored slot counts disagree");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r >= LVLC_W'(1)) && (top_r <= LVLC_W'(MAX_LEVELS)))
    else $error("top level out of range");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result word raised outside the result state");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !((in_tdata[1:0] == FUNC_INSERT) && store_full)) |=> (state_r == ST_LVL))
    else $error("accepted operation did not start its descent");

endmodule
